// ===== rtl/core/lsic_pkg.sv =====
// Shared constants for the line segment intersection core.
package lsic_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int TOL_BITS       = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 3;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

    // register indexes
    localparam logic REG_TOLERANCE = 1'b0;

    // result codes
    localparam logic [1:0] OUT_CROSS_IN  = 2'd0;
    localparam logic [1:0] OUT_CROSS_OUT = 2'd1;
    localparam logic [1:0] OUT_PARALLEL  = 2'd2;
    localparam logic [1:0] OUT_COINCIDE  = 2'd3;

endpackage

// ===== rtl/core/lsic_if.sv =====
// Valid/ready channel interfaces for line pairs and crossing results.
interface lsic_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_origin_x;
    logic signed [W-1:0] a_origin_y;
    logic        [W-2:0] a_extent;
    logic signed [W-1:0] a_normal_x;
    logic signed [W-1:0] a_normal_y;
    logic signed [W-1:0] a_offset;
    logic signed [W-1:0] b_origin_x;
    logic signed [W-1:0] b_origin_y;
    logic        [W-2:0] b_extent;
    logic signed [W-1:0] b_normal_x;
    logic signed [W-1:0] b_normal_y;
    logic signed [W-1:0] b_offset;

    modport source (
        output valid, a_origin_x, a_origin_y, a_extent, a_normal_x, a_normal_y, a_offset,
               b_origin_x, b_origin_y, b_extent, b_normal_x, b_normal_y, b_offset,
        input  ready
    );
    modport sink (
        input  valid, a_origin_x, a_origin_y, a_extent, a_normal_x, a_normal_y, a_offset,
               b_origin_x, b_origin_y, b_extent, b_normal_x, b_normal_y, b_offset,
        output ready
    );
endinterface

interface lsic_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic                hit;
    logic        [1:0]   outcome;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;

    modport source (output valid, hit, outcome, point_x, point_y, input ready);
    modport sink   (input  valid, hit, outcome, point_x, point_y, output ready);
endinterface

// ===== rtl/core/line_segment_intersection_core.sv =====
// Line pair crossing by Cramer's rule with a chain of one-bit division cells.
// Throughput: one beat per cycle; the COORD_BITS division cells set the depth.
// A stalled result holds the whole pipeline; new beats are taken whenever it moves.
// Reset (synchronous, active low) clears all valid flags and sets tolerance to 1.
module line_segment_intersection_core #(
    parameter int COORD_BITS = lsic_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lsic_in_if.sink                              i_item,
    lsic_out_if.source                           o_res,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsic_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [lsic_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [lsic_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import lsic_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int PW = 2 * W + 1;
    localparam int RW = 3 * W + 1;
    localparam int NV = W + 5;

    typedef struct packed {
        logic signed [W-1:0] aox;
        logic signed [W-1:0] aoy;
        logic        [W-2:0] aex;
        logic signed [W-1:0] box;
        logic signed [W-1:0] boy;
        logic        [W-2:0] bex;
    } t_side;

    typedef struct packed {
        logic par;
        logic coin;
        logic negx;
        logic negy;
        logic ovfx;
        logic ovfy;
    } t_flg;

    logic               w_en;
    logic [TOL_BITS-1:0] r_tol;
    logic [NV-1:0]      r_vld;

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TOLERANCE) begin
            prdata = CFG_DATA_BITS'(r_tol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TOLERANCE) begin
            r_tol <= pwdata[TOL_BITS-1:0];
        end
    end

    // global advance
    assign w_en         = !o_res.valid || o_res.ready;
    assign i_item.ready = w_en;

    // valid flags through all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            o_res.valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NV-2:0], i_item.valid};
            o_res.valid <= r_vld[NV-1];
        end
    end

    // stage 1: products
    logic signed [PW-1:0] r1_pab, r1_pba, r1_nx1, r1_nx2, r1_ny1, r1_ny2;
    logic signed [W:0]    r1_dc;
    t_side                r_sd [0:W+3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pab <= PW'(i_item.a_normal_x * i_item.b_normal_y);
            r1_pba <= PW'(i_item.b_normal_x * i_item.a_normal_y);
            r1_nx1 <= PW'(i_item.a_normal_y * i_item.b_offset);
            r1_nx2 <= PW'(i_item.b_normal_y * i_item.a_offset);
            r1_ny1 <= PW'(i_item.b_normal_x * i_item.a_offset);
            r1_ny2 <= PW'(i_item.a_normal_x * i_item.b_offset);
            r1_dc  <= (W+1)'(i_item.a_offset) - (W+1)'(i_item.b_offset);
            r_sd[0] <= '{aox: i_item.a_origin_x, aoy: i_item.a_origin_y,
                         aex: i_item.a_extent,   box: i_item.b_origin_x,
                         boy: i_item.b_origin_y, bex: i_item.b_extent};
            for (int k = 1; k <= W + 3; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // stage 2: determinant and numerators
    logic signed [PW-1:0] r2_det, r2_numx, r2_numy;
    logic                 r2_coin;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_det  <= r1_pab - r1_pba;
            r2_numx <= r1_nx1 - r1_nx2;
            r2_numy <= r1_ny1 - r1_ny2;
            r2_coin <= (r1_dc[W] ? -r1_dc : r1_dc) <= (W+1)'(r_tol);
        end
    end

    // stage 3: magnitudes, quotient overflow and parallel test
    logic [PW-1:0] w_dmag, w_xmag, w_ymag;
    logic [RW-1:0] w_ax, w_ay, w_dtop;
    logic [PW-1:0] r3_den;
    logic [RW-1:0] r3_ax, r3_ay;
    t_flg          r_fl [0:W];

    always_comb begin
        w_dmag = r2_det[PW-1]  ? PW'(-r2_det)  : PW'(r2_det);
        w_xmag = r2_numx[PW-1] ? PW'(-r2_numx) : PW'(r2_numx);
        w_ymag = r2_numy[PW-1] ? PW'(-r2_numy) : PW'(r2_numy);
        w_ax   = RW'(w_xmag) << FRAC_BITS;
        w_ay   = RW'(w_ymag) << FRAC_BITS;
        w_dtop = RW'(w_dmag) << W;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_den  <= w_dmag;
            r3_ax   <= w_ax;
            r3_ay   <= w_ay;
            r_fl[0] <= '{par:  w_dmag <= (PW'(r_tol) << FRAC_BITS),
                         coin: r2_coin,
                         negx: r2_numx[PW-1] ^ r2_det[PW-1],
                         negy: r2_numy[PW-1] ^ r2_det[PW-1],
                         ovfx: w_ax >= w_dtop,
                         ovfy: w_ay >= w_dtop};
            for (int k = 1; k <= W; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    // division cells, most significant quotient bit first
    logic [PW-1:0] w_den  [0:W];
    logic [RW-1:0] w_remx [0:W];
    logic [RW-1:0] w_remy [0:W];
    logic [W-1:0]  w_quox [0:W];
    logic [W-1:0]  w_quoy [0:W];

    assign w_den[0]  = r3_den;
    assign w_remx[0] = r3_ax;
    assign w_remy[0] = r3_ay;
    assign w_quox[0] = '0;
    assign w_quoy[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        lsic_div_cell #(.W(W), .BIT(W - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_den   (w_den[g]),
            .i_rem_x (w_remx[g]),
            .i_rem_y (w_remy[g]),
            .i_quo_x (w_quox[g]),
            .i_quo_y (w_quoy[g]),
            .o_den   (w_den[g+1]),
            .o_rem_x (w_remx[g+1]),
            .o_rem_y (w_remy[g+1]),
            .o_quo_x (w_quox[g+1]),
            .o_quo_y (w_quoy[g+1])
        );
    end

    // sign and saturation stage after the division cells
    function automatic logic [W-1:0] f_sat(input logic [W-1:0] q, input logic neg,
                                            input logic ovf);
        logic [W-1:0] res;
        if (!neg) begin
            res = (ovf || q[W-1]) ? {1'b0, {(W-1){1'b1}}} : q;
        end else begin
            res = (ovf || (q[W-1] && (|q[W-2:0]))) ? {1'b1, {(W-1){1'b0}}} : -q;
        end
        return res;
    endfunction

    logic signed [W-1:0] r4_px, r4_py;
    logic                r4_par, r4_coin;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_par  <= r_fl[W].par;
            r4_coin <= r_fl[W].coin;
            if (r_fl[W].par) begin
                r4_px <= '0;
                r4_py <= '0;
            end else begin
                r4_px <= f_sat(w_quox[W], r_fl[W].negx, r_fl[W].ovfx);
                r4_py <= f_sat(w_quoy[W], r_fl[W].negy, r_fl[W].ovfy);
            end
        end
    end

    // bounds stage 1: offsets from centres and squares
    logic signed [W:0]     w_dxa, w_dya, w_dxb, w_dyb;
    logic signed [2*W+1:0] r5_sxa, r5_sya, r5_sxb, r5_syb;
    logic        [2*W-3:0] r5_ea, r5_eb;
    logic                  r5_ua, r5_ub, r5_par, r5_coin;
    logic signed [W-1:0]   r5_px, r5_py;

    always_comb begin
        w_dxa = (W+1)'(r4_px) - (W+1)'(r_sd[W+3].aox);
        w_dya = (W+1)'(r4_py) - (W+1)'(r_sd[W+3].aoy);
        w_dxb = (W+1)'(r4_px) - (W+1)'(r_sd[W+3].box);
        w_dyb = (W+1)'(r4_py) - (W+1)'(r_sd[W+3].boy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_sxa  <= (2*W+2)'(w_dxa * w_dxa);
            r5_sya  <= (2*W+2)'(w_dya * w_dya);
            r5_sxb  <= (2*W+2)'(w_dxb * w_dxb);
            r5_syb  <= (2*W+2)'(w_dyb * w_dyb);
            r5_ea   <= (2*W-2)'(r_sd[W+3].aex * r_sd[W+3].aex);
            r5_eb   <= (2*W-2)'(r_sd[W+3].bex * r_sd[W+3].bex);
            r5_ua   <= &r_sd[W+3].aex;
            r5_ub   <= &r_sd[W+3].bex;
            r5_par  <= r4_par;
            r5_coin <= r4_coin;
            r5_px   <= r4_px;
            r5_py   <= r4_py;
        end
    end

    // bounds stage 2: compare and classify into the output register
    logic [2*W+2:0] w_da, w_db;
    logic           w_in;
    logic [1:0]     w_oc;

    always_comb begin
        w_da = (2*W+3)'(r5_sxa) + (2*W+3)'(r5_sya);
        w_db = (2*W+3)'(r5_sxb) + (2*W+3)'(r5_syb);
        w_in = (r5_ua || (w_da <= (2*W+3)'(r5_ea))) &&
               (r5_ub || (w_db <= (2*W+3)'(r5_eb)));
        if (r5_par) begin
            w_oc = r5_coin ? OUT_COINCIDE : OUT_PARALLEL;
        end else begin
            w_oc = w_in ? OUT_CROSS_IN : OUT_CROSS_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_res.outcome <= w_oc;
            o_res.hit     <= (w_oc == OUT_CROSS_IN) || (w_oc == OUT_COINCIDE);
            o_res.point_x <= r5_px;
            o_res.point_y <= r5_py;
        end
    end
endmodule

// ===== rtl/core/lsic_div_cell.sv =====
// One restoring division cell: produces one quotient bit of both coordinates.
module lsic_div_cell #(
    parameter int W   = 32,
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W:0]   i_den,
    input  logic [3*W:0]   i_rem_x,
    input  logic [3*W:0]   i_rem_y,
    input  logic [W-1:0]   i_quo_x,
    input  logic [W-1:0]   i_quo_y,
    output logic [2*W:0]   o_den,
    output logic [3*W:0]   o_rem_x,
    output logic [3*W:0]   o_rem_y,
    output logic [W-1:0]   o_quo_x,
    output logic [W-1:0]   o_quo_y
);
    localparam int RW = 3 * W + 1;

    logic [RW-1:0] w_dsh;
    logic          w_take_x;
    logic          w_take_y;
    logic [RW-1:0] n_rem_x;
    logic [RW-1:0] n_rem_y;
    logic [W-1:0]  n_quo_x;
    logic [W-1:0]  n_quo_y;

    // trial subtract of the shifted divisor
    always_comb begin
        w_dsh    = RW'(i_den) << BIT;
        w_take_x = i_rem_x >= w_dsh;
        w_take_y = i_rem_y >= w_dsh;
        n_rem_x  = w_take_x ? i_rem_x - w_dsh : i_rem_x;
        n_rem_y  = w_take_y ? i_rem_y - w_dsh : i_rem_y;
        n_quo_x  = i_quo_x;
        n_quo_y  = i_quo_y;
        n_quo_x[BIT] = w_take_x;
        n_quo_y[BIT] = w_take_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den   <= i_den;
            o_rem_x <= n_rem_x;
            o_rem_y <= n_rem_y;
            o_quo_x <= n_quo_x;
            o_quo_y <= n_quo_y;
        end
    end
endmodule

// ===== tb/lsic_tb_checker.sv =====
// Result checker for the line crossing core: predicts each crossing and compares beats.
module lsic_tb_checker #(
    parameter int W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsic_in_if.sink           i_mon_in,
    lsic_out_if.sink          i_mon_out,
    input  logic [15:0]       i_tolerance,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_in_beats
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsic_pkg::*;

    typedef struct packed {
        logic                hit;
        logic [1:0]          outcome;
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
    } t_crossing;

    t_crossing crossing_q[$];
    int        fail_count  = 0;
    int        checked     = 0;
    int        in_beats    = 0;
    int        pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked;
    assign o_in_beats   = in_beats;

    // (num << 16) / den truncated toward zero, saturated to W bits
    function automatic logic signed [W-1:0] div_sat(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic signed [127:0] q;
        logic signed [127:0] maxp;
        logic signed [127:0] minn;
        maxp = (128'sd1 <<< (W-1)) - 1;
        minn = -(128'sd1 <<< (W-1));
        q = (num <<< FRAC_BITS) / den;
        if (q > maxp) return maxp[W-1:0];
        if (q < minn) return minn[W-1:0];
        return q[W-1:0];
    endfunction

    // squared distance test against a half-length; all ones is unbounded
    function automatic bit within_extent(logic signed [W-1:0] px, logic signed [W-1:0] py,
                                         logic signed [W-1:0] ox, logic signed [W-1:0] oy,
                                         logic [W-2:0] ext);
        logic signed [127:0] dx;
        logic signed [127:0] dy;
        logic signed [127:0] e;
        if (&ext) return 1'b1;
        dx = 128'(signed'(px)) - 128'(signed'(ox));
        dy = 128'(signed'(py)) - 128'(signed'(oy));
        e  = {97'd0, ext};
        return (dx * dx + dy * dy) <= e * e;
    endfunction

    function automatic t_crossing predict_crossing(logic [15:0] tol);
        t_crossing r;
        logic signed [127:0] anx, any, ac, bnx, bny, bc, det, mdet, dc;
        anx = i_mon_in.a_normal_x; any = i_mon_in.a_normal_y; ac = i_mon_in.a_offset;
        bnx = i_mon_in.b_normal_x; bny = i_mon_in.b_normal_y; bc = i_mon_in.b_offset;
        r   = '0;
        det = anx * bny - bnx * any;
        mdet = det < 0 ? -det : det;
        if (mdet <= ({112'd0, tol} << FRAC_BITS)) begin
            dc = ac - bc;
            if (dc < 0) dc = -dc;
            r.outcome = (dc <= {112'd0, tol}) ? OUT_COINCIDE : OUT_PARALLEL;
            r.hit     = (r.outcome == OUT_COINCIDE);
        end else begin
            r.px = div_sat(any * bc - bny * ac, det);
            r.py = div_sat(bnx * ac - anx * bc, det);
            if (within_extent(r.px, r.py, i_mon_in.a_origin_x, i_mon_in.a_origin_y,
                              i_mon_in.a_extent) &&
                within_extent(r.px, r.py, i_mon_in.b_origin_x, i_mon_in.b_origin_y,
                              i_mon_in.b_extent)) begin
                r.outcome = OUT_CROSS_IN;
                r.hit     = 1'b1;
            end else begin
                r.outcome = OUT_CROSS_OUT;
            end
        end
        return r;
    endfunction

    // sample both channels at the edge
    always @(posedge i_clk) begin
        t_crossing exp_r;
        if (i_rst_n) begin
            if (i_mon_in.valid && i_mon_in.ready) begin
                crossing_q.push_back(predict_crossing(i_tolerance));
                in_beats++;
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (crossing_q.size() == 0) begin
                    $display("%0t: unexpected result beat hit=%0b outcome=%0d", $time,
                             i_mon_out.hit, i_mon_out.outcome);
                    fail_count++;
                end else begin
                    exp_r = crossing_q.pop_front();
                    checked++;
                    if (i_mon_out.hit !== exp_r.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit,
                                 i_mon_out.hit);
                        fail_count++;
                    end
                    if (i_mon_out.outcome !== exp_r.outcome) begin
                        $display("%0t: outcome expected %0d actual %0d", $time,
                                 exp_r.outcome, i_mon_out.outcome);
                        fail_count++;
                    end
                    if (i_mon_out.point_x !== exp_r.px) begin
                        $display("%0t: point_x expected %h actual %h", $time, exp_r.px,
                                 i_mon_out.point_x);
                        fail_count++;
                    end
                    if (i_mon_out.point_y !== exp_r.py) begin
                        $display("%0t: point_y expected %h actual %h", $time, exp_r.py,
                                 i_mon_out.point_y);
                        fail_count++;
                    end
                end
            end
            pending_cnt = crossing_q.size();
        end
    end
endmodule

// ===== tb/line_segment_intersection_core_tb.sv =====
// Stimulus and verdict for the line crossing core testbench.
module line_segment_intersection_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsic_pkg::*;

    localparam int W       = 32;
    localparam int LATENCY = W + 6;
    localparam int WDOG    = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic pready;
    logic [15:0] tol_shadow = TOL_RESET;
    bit   no_idle = 1'b0;
    int   fail_count, pending, checked, in_beats;
    int   idle_cycles = 0;
    int   settings_used = 0;

    lsic_in_if  #(.W(W)) item_if ();
    lsic_out_if #(.W(W)) res_if ();

    line_segment_intersection_core #(.COORD_BITS(W)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_if.sink), .o_res(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lsic_tb_checker #(.W(W)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mon_in(item_if.sink),
        .i_mon_out(res_if.sink), .i_tolerance(tol_shadow), .o_fail_count(fail_count),
        .o_pending(pending), .o_checked(checked), .o_in_beats(in_beats)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        item_if.valid = 1'b0;
        {item_if.a_origin_x, item_if.a_origin_y, item_if.a_extent, item_if.a_normal_x,
         item_if.a_normal_y, item_if.a_offset, item_if.b_origin_x, item_if.b_origin_y,
         item_if.b_extent, item_if.b_normal_x, item_if.b_normal_y, item_if.b_offset} = '0;
        res_if.ready = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        res_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // watchdog on cycles without any beat or configuration access
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // tolerance write: setup then access beat
    task automatic write_tolerance(logic [15:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= CFG_ADDR_BITS'(REG_TOLERANCE) << 2; pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tol_shadow = v;
        settings_used++;
    endtask

    function automatic logic [W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sd65536 * $signed($urandom_range(64) - 32);
            2: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return $signed($urandom_range(8)) - 4;
            default: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
        endcase
    endfunction

    function automatic logic [W-2:0] rand_extent();
        case ($urandom_range(3))
            0: return '1;
            1: return 31'($urandom);
            default: return 31'($urandom_range(32'h00ff_ffff));
        endcase
    endfunction

    // one line pair beat; hold until taken
    task automatic send_pair(logic [W-1:0] aox, aoy, logic [W-2:0] aex,
                             logic [W-1:0] anx, any, ac, box, boy,
                             logic [W-2:0] bex, logic [W-1:0] bnx, bny, bc);
        while (!no_idle && $urandom_range(99) < 18) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.a_origin_x <= aox; item_if.a_origin_y <= aoy; item_if.a_extent <= aex;
        item_if.a_normal_x <= anx; item_if.a_normal_y <= any; item_if.a_offset <= ac;
        item_if.b_origin_x <= box; item_if.b_origin_y <= boy; item_if.b_extent <= bex;
        item_if.b_normal_x <= bnx; item_if.b_normal_y <= bny; item_if.b_offset <= bc;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    task automatic send_random();
        logic [W-1:0] anx, any, k;
        anx = rand_coord(); any = rand_coord();
        case ($urandom_range(4))
            // near-parallel pair sharing a scaled normal
            0: begin
                k = $urandom_range(3) + 1;
                send_pair(rand_coord(), rand_coord(), rand_extent(), anx, any, rand_coord(),
                          rand_coord(), rand_coord(), rand_extent(), anx * k, any * k,
                          $urandom_range(1) ? rand_coord() : rand_coord() & 32'h3);
            end
            default: send_pair(rand_coord(), rand_coord(), rand_extent(), anx, any,
                               rand_coord(), rand_coord(), rand_coord(), rand_extent(),
                               rand_coord(), rand_coord(), rand_coord());
        endcase
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    localparam logic [W-1:0] ONE = 32'h0001_0000;
    localparam logic [W-1:0] MAXC = 32'h7fff_ffff;
    localparam logic [W-1:0] MINC = 32'h8000_0000;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: axis crossings, bounds, parallel, coincident, saturation
        send_pair(0, 0, '1, ONE, 0, -ONE, 0, 0, '1, 0, ONE, -ONE);
        send_pair(0, 0, 31'h1_0000, ONE, 0, -ONE, 0, 0, 31'h1_0000, 0, ONE, -ONE);
        send_pair(0, 0, 31'h2_0000, ONE, 0, -ONE, 0, 0, 31'h2_0000, 0, ONE, -ONE);
        send_pair(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE, 0);
        send_pair(0, 0, '1, ONE, 0, ONE, 0, 0, '1, ONE, 0, 3 * ONE);
        send_pair(0, 0, '1, ONE, 0, ONE, 0, 0, '1, ONE, 0, ONE);
        send_pair(0, 0, '1, ONE, 0, 5, 0, 0, '1, ONE, 0, 6);
        send_pair(0, 0, '1, 1, 0, MAXC, 0, 0, '1, 0, 32'h0002_0000, MINC);
        send_pair(0, 0, 31'h7fff_fffe, 32'h10, 1, MINC, 0, 0, '1, 1, 32'h10, MAXC);
        send_pair(MAXC, MINC, '1, MAXC, MINC, MAXC, MINC, MAXC, '1, MINC, MAXC, MINC);
        send_pair(MINC, MINC, '1, MINC, MINC, MINC, MAXC, MAXC, '1, MINC, MAXC, 0);
        send_pair(0, 0, '1, 0, 0, 0, 0, 0, '1, 0, 0, 32'hffff_ffff);
        send_pair(-1, -1, '1, -1, -1, -1, -1, -1, '1, -1, 1, -1);
        drain();

        // zero tolerance
        write_tolerance(16'd0);
        send_pair(0, 0, '1, ONE, 0, ONE, 0, 0, '1, ONE, 0, ONE + 1);
        send_pair(0, 0, '1, 1, 0, 0, 0, 0, '1, 0, 1, 0);
        send_pair(0, 0, '1, ONE, 0, 7, 0, 0, '1, ONE, 0, 7);
        drain();

        // random phases across tolerance settings, one without idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_tolerance(16'hffff);
                1: write_tolerance(16'($urandom));
                2: write_tolerance(16'd1);
                default: write_tolerance(16'd0);
            endcase
            no_idle = (ph == 2);
            for (int n = 0; n < 400; n++) send_random();
            drain();
        end
        no_idle = 1'b0;

        $display("tb: %0d line pairs sent, %0d results checked", in_beats, checked);
        $display("tb: %0d tolerance settings including both extremes", settings_used);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/lsic_pkg.sv
rtl/core/lsic_if.sv
rtl/core/lsic_div_cell.sv
rtl/core/line_segment_intersection_core.sv
tb/lsic_tb_checker.sv
tb/line_segment_intersection_core_tb.sv
